[hw/rtl/prime_test_trial_division_macros.svh]
// Assertion macros shared by the RTL files of the primality tester.
// All of them sample on the rising edge of clk and stay quiet during reset.
`ifndef PRIME_TEST_TRIAL_DIVISION_MACROS_SVH
`define PRIME_TEST_TRIAL_DIVISION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[hw/rtl/prime_td_pkg.sv]
`default_nettype none

package prime_td_pkg;

	// Width of the number under test.
	localparam int VALUE_WIDTH = 32;
	// Width of the bit counter of the divider.
	localparam int CNT_W = $clog2(VALUE_WIDTH);

	// First trial divisor once even values are settled.
	localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(3);
	localparam logic [VALUE_WIDTH-1:0] DIVISOR_STEP = VALUE_WIDTH'(2);
	localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(2);

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// Request to the divider: load starts a new division.
	typedef struct packed {
		logic   load;
		value_t dividend;
		value_t divisor;
	} div_req_t;

	// Response of the divider: rem and quot are valid while done is high.
	typedef struct packed {
		logic   done;
		value_t rem;
		value_t quot;
	} div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/prime_td_divider.sv]
`default_nettype none

module prime_td_divider (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire prime_td_pkg::div_req_t req,
	output prime_td_pkg::div_rsp_t      rsp
);
	import prime_td_pkg::*;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	value_t           shift_q;
	value_t           rem_q;
	value_t           quot_q;
	value_t           divisor_q;

	logic [VALUE_WIDTH:0] trial;
	value_t               diff;
	logic                 ge;
	value_t               rem_next;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	// When the divisor fits, the difference is below the divisor, so the low bits
	// of the subtraction are the whole result.
	always_comb begin
		trial    = {rem_q, shift_q[VALUE_WIDTH-1]};
		diff     = trial[VALUE_WIDTH-1:0] - divisor_q;
		ge       = trial >= {1'b0, divisor_q};
		rem_next = ge ? diff : trial[VALUE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_LAST);
			if (req.load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_LAST) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			shift_q   <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
			quot_q    <= '0;
		end else if (run_q) begin
			shift_q <= {shift_q[VALUE_WIDTH-2:0], 1'b0};
			rem_q   <= rem_next;
			quot_q  <= {quot_q[VALUE_WIDTH-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

[hw/rtl/prime_test_trial_division.sv]
// Trial-division primality tester.
// A word is handed over by raising start with the number on value; it is taken
// at a rising edge where start is high and busy is low. Exactly one result word
// follows: prime_flag is valid for the single cycle in which done is high, and the
// receiver must take it then, since it cannot hold the block off.
// Values below two and even values are settled at once: done rises in the cycle
// after the start word. Any other value is divided by 3, 5, 7 and so on, one
// quotient bit per cycle in a shift-subtract divider, one trial divisor after
// another. The search ends when the quotient drops below the divisor (prime)
// or, with the quotient not below it, a remainder is zero (composite), so a
// prime near the top of a 32-bit range takes about 32768 divisors. One number
// is tested at a time; busy stays high for the whole search and a new word
// may be given in the cycle in which done shows. An asynchronous low level on
// arst_n aborts any search, drops busy and done, and leaves the block ready
// for a new word.
`default_nettype none
`include "prime_test_trial_division_macros.svh"

module prime_test_trial_division (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic [prime_td_pkg::VALUE_WIDTH-1:0] value,
	output logic                                      busy,
	output logic                                      done,
	output logic                                      prime_flag
);
	import prime_td_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

	state_t   state_q;
	value_t   n_q;
	value_t   d_q;
	logic     done_q;
	logic     prime_flag_q;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic   accept;
	logic   trivial;
	value_t d_next;

	assign accept = start && (state_q == ST_IDLE);
	// Zero, one, two and every even number need no division at all.
	assign trivial = (value[VALUE_WIDTH-1:1] == '0) || !value[0];
	assign d_next  = d_q + DIVISOR_STEP;

	// A new division starts either on a fresh odd word above one or when the
	// last trial divisor turned out neither a bound nor a factor.
	always_comb begin
		div_req.load     = 1'b0;
		div_req.dividend = n_q;
		div_req.divisor  = d_next;
		if (accept) begin
			div_req.load     = !trivial;
			div_req.dividend = value;
			div_req.divisor  = FIRST_DIVISOR;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			div_req.load = (div_rsp.quot >= d_q) && (div_rsp.rem != '0);
		end
	end

	prime_td_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (trivial) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// The quotient below the divisor means the divisor squared
					// exceeds the value, so no factor is left to find.
					if (div_rsp.done && ((div_rsp.quot < d_q) || (div_rsp.rem == '0))) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q          <= value;
			d_q          <= FIRST_DIVISOR;
			prime_flag_q <= (value == SMALLEST_PRIME);
		end else if (state_q == ST_DIV && div_rsp.done) begin
			// A remainder of zero found before the bound marks a composite.
			prime_flag_q <= div_rsp.quot < d_q;
			d_q          <= d_next;
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign prime_flag = prime_flag_q;

	`PTD_ASSERT_NEXT(a_accept_answered, start && !busy, busy || done, "word not handled")
	`PTD_ASSERT_SAME(a_no_result_in_search, busy, !done, "result strobe during a search")
	`PTD_ASSERT_SAME(a_divisor_odd, busy, d_q[0], "trial divisor became even")
	`PTD_ASSERT_SAME(a_div_done_only_busy, div_rsp.done, busy, "divider done outside a search")

endmodule

`default_nettype wire

[bench/prime_test_trial_division_checker.sv]
`default_nettype none

module prime_test_trial_division_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire prime_td_pkg::value_t value,
	input  wire logic                 done,
	input  wire logic                 prime_flag,
	output int unsigned               failures,
	output int unsigned               outstanding
);
	import prime_td_pkg::*;

	typedef struct {
		value_t number;
		logic   prime;
	} verdict_t;

	verdict_t pending_verdicts[$];
	verdict_t oldest;

	// Odd divisors from 5 upward, bounded by an exact d <= n / d compare.
	function automatic logic trial_division_verdict(value_t number);
		logic [63:0] n;
		logic [63:0] d;
		n = 64'(number);
		if (n < 2)
			return 1'b0;
		if (n == 2 || n == 3)
			return 1'b1;
		if (n % 2 == 0 || n % 3 == 0)
			return 1'b0;
		for (d = 5; d <= n / d; d += 2)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// A word that shows in the same cycle as a new start belongs to an older
	// number, so the check runs before the new verdict is queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_verdicts.size() == 0) begin
					if (failures < 10)
						$display("%0t: result word prime_flag=%b with no number waiting",
							$time, prime_flag);
					failures++;
				end else begin
					oldest = pending_verdicts.pop_front();
					if (prime_flag !== oldest.prime) begin
						if (failures < 10)
							$display("%0t: value %0d: prime_flag expected %b, got %b",
								$time, oldest.number, oldest.prime, prime_flag);
						failures++;
					end
				end
			end
			if (start && !busy)
				pending_verdicts.push_back('{value, trial_division_verdict(value)});
		end
		outstanding = pending_verdicts.size();
	end

endmodule

`default_nettype wire

[bench/tb_prime_test_trial_division.sv]
`default_nettype none

// Bench for the trial-division primality tester. The top only makes words and
// gives the verdict; a checker beside the block watches both sides, predicts
// the primality of every accepted number and compares it with the result word.
module tb_prime_test_trial_division;
	import prime_td_pkg::*;

	// The slowest number used here is a prime just under 2^26; even if every
	// random number needed its longest search the run would stay under this
	// limit, so it only catches a hung search.
	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	// Once the last result word is in, the run waits on so that a stray one
	// would still show.
	localparam int DRAIN_CYCLES = 4 * (VALUE_WIDTH + 1);
	localparam int RANDOM_WORDS = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	value_t      value = '0;
	logic        busy;
	logic        done;
	logic        prime_flag;
	int unsigned failures;
	int unsigned outstanding;
	int unsigned cycles = 0;
	bit          idle_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	prime_test_trial_division dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.busy       (busy),
		.done       (done),
		.prime_flag (prime_flag)
	);

	prime_test_trial_division_checker verdict_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.done        (done),
		.prime_flag  (prime_flag),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// A hung search or a lost handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Random numbers are shaped so that the search stays short: most are small,
	// and the wide ones are built with a small factor so that all 32 bits toggle
	// without paying for a full search up to 65536. A smaller share are odd
	// products and odd numbers up to 2^20, which force long runs of divisors.
	function automatic value_t random_number();
		int unsigned pick;
		int unsigned factor;
		value_t      raw;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return value_t'($urandom_range(0, 300));
		if (pick < 55)
			return value_t'($urandom_range(0, 65535));
		if (pick < 80) begin
			factor = $urandom_range(2, 97);
			raw = $urandom;
			return raw - raw % factor;
		end
		if (pick < 90)
			return value_t'(($urandom_range(1, 511) * 2 + 1) * ($urandom_range(1, 511) * 2 + 1));
		return value_t'($urandom_range(0, (1 << 20) - 1) | 1);
	endfunction

	// Called at a falling edge; returns at the falling edge after the word was
	// taken, with start still high so that back-to-back words need no gap.
	task automatic offer_number(value_t number);
		int  gap;
		bit  taken;
		if (idle_on && $urandom_range(0, 1) == 1) begin
			gap = $urandom_range(1, 19);
			start <= 1'b0;
			value <= $urandom;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		value <= number;
		do begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	// Holds the sender off until every queued number has its result word.
	task automatic wait_for_results();
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		// The directed words cover the cases settled without a search (below
		// two, two and three, multiples of two and three), squares of primes
		// where the divisor squared meets the number exactly, a few primes that
		// need a long search, and patterns that drive every bit of value both
		// ways.
		value_t directed[] = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
			32'd25, 32'd35, 32'd49, 32'd97, 32'd121,
			32'd1000003, 32'd16752649, 32'd67108859,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
			32'hFFFF_FFFE, 32'hFFFF_FFFF
		};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		idle_on = 1'b1;
		foreach (directed[i])
			offer_number(directed[i]);
		wait_for_results();

		// Idling switches on and off in stretches of ten words, and the last
		// stretches run with no gaps at all so that back-to-back starts in the
		// cycle of the result word get exercised.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 10 == 0)
				idle_on = (i < RANDOM_WORDS - 20) && ($urandom_range(0, 1) == 1);
			if (i == RANDOM_WORDS / 2)
				wait_for_results();
			offer_number(random_number());
		end
		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (failures == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/prime_td_pkg.sv
hw/rtl/prime_td_divider.sv
hw/rtl/prime_test_trial_division.sv
bench/prime_test_trial_division_checker.sv
bench/tb_prime_test_trial_division.sv
